// File: design/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

   // default sizes
   localparam int DEPTH_DEFAULT     = 1024;
   localparam int WORD_BITS_DEFAULT = 32;

   // field widths
   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 10;
   localparam int OCC_W    = 11;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_WRITE      = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // what a cell does with its stored entry
   typedef enum logic [1:0] {
      DATA_HOLD,
      DATA_SHIFT_BACK,
      DATA_SHIFT_FRONT,
      DATA_WRITE
   } data_op_type;

   // what a cell does with its read chain stage
   typedef enum logic [1:0] {
      RD_HOLD,
      RD_SNAP,
      RD_SHIFT
   } rd_op_type;

   typedef struct packed {
      data_op_type data_op;
      rd_op_type   rd_op;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: design/deq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface deq_req_if;
   logic                                valid;
   logic                                ready;
   logic [deq_pkg::FUNC_W-1:0]          func;
   logic signed [deq_pkg::VALUE_W-1:0]  value;
   logic [deq_pkg::POS_W-1:0]           position;

   modport source (output valid, output func, output value, output position, input ready);
   modport sink   (input valid, input func, input value, input position, output ready);
endinterface

`default_nettype wire

// File: design/deq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface deq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [deq_pkg::VALUE_W-1:0]   read_data;
   logic [deq_pkg::OCC_W-1:0]            occupancy;
   logic [deq_pkg::STATUS_W-1:0]         status;

   modport source (output valid, output read_data, output occupancy, output status,
                   input ready);
   modport sink   (input valid, input read_data, input occupancy, input status,
                   output ready);
endinterface

`default_nettype wire

// File: design/double_ended_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of words held in a row of DEPTH cells, the
// front entry in cell 0. Push back, pop back, pop front, push front and
// write update the row at once: each cell holds its entry, moves it to a
// neighbor or takes the word when addressed, all in the same clock. A read
// at position p has all cells copy their entries into a second chain of
// registers, which then shifts one cell per cycle toward cell 0 until the
// wanted entry arrives. Each operation gives one transfer on the result
// channel with read data, occupancy and status; refused operations (push
// when full, pop when empty, position not below the occupancy) leave the
// queue unchanged. The result is held in an output register, and a new
// request is taken when no read is in progress and that register is free
// or is being emptied in the same cycle. Stored words need no reset.
module double_ended_queue_unit #(
   parameter int DEPTH     = deq_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = deq_pkg::WORD_BITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   deq_req_if.sink     req_if,
   deq_rsp_if.source   rsp_if
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type                           state_ff, state_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [IDX_W-1:0]                    shift_ff, shift_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [deq_pkg::VALUE_W-1:0]         rsp_data_ff, rsp_data_in;
   logic [deq_pkg::OCC_W-1:0]           rsp_occ_ff, rsp_occ_in;
   logic [deq_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;

   deq_pkg::cell_ctrl_type              ctrl;
   logic [IDX_W-1:0]                    target;
   logic [WORD_BITS-1:0]                value_word;
   logic                                req_accept;
   logic                                is_full;
   logic                                is_empty;
   logic                                pos_bad;

   logic [WORD_BITS-1:0]                cell_data [DEPTH];
   logic [WORD_BITS-1:0]                cell_rd   [DEPTH];

   assign value_word = WORD_BITS'($unsigned(req_if.value));
   assign req_if.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_accept = req_if.valid && req_if.ready;
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign pos_bad  = (32'(req_if.position) >= 32'(count_ff));

   // operation decode and sequencing
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      shift_in      = shift_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_status_in = rsp_status_ff;
      ctrl          = '{data_op: deq_pkg::DATA_HOLD, rd_op: deq_pkg::RD_HOLD};
      target        = IDX_W'(count_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = deq_pkg::ST_OK;
               unique case (req_if.func) inside
                  deq_pkg::FUNC_PUSH_BACK, deq_pkg::FUNC_PUSH_FRONT: begin
                     if (is_full) begin
                        rsp_status_in = deq_pkg::ST_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                        ctrl.data_op = (req_if.func == deq_pkg::FUNC_PUSH_BACK) ?
                                       deq_pkg::DATA_WRITE : deq_pkg::DATA_SHIFT_BACK;
                     end
                  end
                  deq_pkg::FUNC_POP_BACK, deq_pkg::FUNC_POP_FRONT: begin
                     if (is_empty) begin
                        rsp_status_in = deq_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                        if (req_if.func == deq_pkg::FUNC_POP_FRONT) begin
                           ctrl.data_op = deq_pkg::DATA_SHIFT_FRONT;
                        end
                     end
                  end
                  deq_pkg::FUNC_READ, deq_pkg::FUNC_WRITE: begin
                     target = IDX_W'(req_if.position);
                     if (pos_bad) begin
                        rsp_status_in = deq_pkg::ST_RANGE;
                     end else if (req_if.func == deq_pkg::FUNC_READ) begin
                        ctrl.rd_op   = deq_pkg::RD_SNAP;
                        shift_in     = IDX_W'(req_if.position);
                        state_in     = S_READ;
                        rsp_valid_in = 1'b0;
                     end else begin
                        ctrl.data_op = deq_pkg::DATA_WRITE;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_occ_in = deq_pkg::OCC_W'(count_in);
            end
         end
         S_READ: begin
            if (shift_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = deq_pkg::VALUE_W'(cell_rd[0]);
               rsp_occ_in    = deq_pkg::OCC_W'(count_ff);
               rsp_status_in = deq_pkg::ST_OK;
               state_in      = S_IDLE;
            end else begin
               ctrl.rd_op = deq_pkg::RD_SHIFT;
               shift_in   = shift_ff - 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_ff      <= shift_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.read_data = rsp_data_ff;
   assign rsp_if.occupancy = rsp_occ_ff;
   assign rsp_if.status    = rsp_status_ff;

   // row of storage cells, cell 0 holds the front entry
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_BITS-1:0] left_data;
      logic [WORD_BITS-1:0] right_data;
      logic [WORD_BITS-1:0] right_rd;

      if (i == 0) begin : g_first
         assign left_data = value_word;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
         assign right_rd   = '0;
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
         assign right_rd   = cell_rd[i+1];
      end

      deq_cell #(
         .WORD_BITS (WORD_BITS),
         .IDX_W     (IDX_W),
         .INDEX     (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .target     (target),
         .value_word (value_word),
         .left_data  (left_data),
         .right_data (right_data),
         .right_rd   (right_rd),
         .data       (cell_data[i]),
         .rd         (cell_rd[i])
      );
   end

   // occupancy never passes the capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy above capacity");

   // the result register stays empty while a read walks the chain
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !rsp_valid_ff)
      else $error("result pending during read");

   // a pop on an empty queue is refused in the next result
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_empty && (req_if.func == deq_pkg::FUNC_POP_BACK ||
       req_if.func == deq_pkg::FUNC_POP_FRONT))
      |=> (rsp_valid_ff && rsp_status_ff == deq_pkg::ST_EMPTY && count_ff == '0))
      else $error("empty pop not flagged");

   // a full refusal reports a full queue
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == deq_pkg::ST_FULL)
      |-> (rsp_occ_ff == deq_pkg::OCC_W'(DEPTH)))
      else $error("full status with room left");

endmodule

`default_nettype wire

// File: design/deq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_cell #(
   parameter int WORD_BITS = deq_pkg::WORD_BITS_DEFAULT,
   parameter int IDX_W     = 10,
   parameter int INDEX     = 0
) (
   input  wire                          clock,
   input  wire deq_pkg::cell_ctrl_type  ctrl,
   input  wire [IDX_W-1:0]              target,
   input  wire [WORD_BITS-1:0]          value_word,
   input  wire [WORD_BITS-1:0]          left_data,
   input  wire [WORD_BITS-1:0]          right_data,
   input  wire [WORD_BITS-1:0]          right_rd,
   output logic [WORD_BITS-1:0]         data,
   output logic [WORD_BITS-1:0]         rd
);

   logic [WORD_BITS-1:0] data_ff, data_in;
   logic [WORD_BITS-1:0] rd_ff, rd_in;
   logic                 hit;

   assign hit = (target == IDX_W'(INDEX));

   // entry update: move with its neighbors or take the word when addressed
   always_comb begin
      data_in = data_ff;
      case (ctrl.data_op)
         deq_pkg::DATA_SHIFT_BACK:  data_in = left_data;
         deq_pkg::DATA_SHIFT_FRONT: data_in = right_data;
         deq_pkg::DATA_WRITE:       data_in = hit ? value_word : data_ff;
         default:                   data_in = data_ff;
      endcase
   end

   // read chain stage: copy the entry, then pass words toward the front cell
   always_comb begin
      rd_in = rd_ff;
      case (ctrl.rd_op)
         deq_pkg::RD_SNAP:  rd_in = data_ff;
         deq_pkg::RD_SHIFT: rd_in = right_rd;
         default:           rd_in = rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rd_ff   <= rd_in;
   end

   assign data = data_ff;
   assign rd   = rd_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int DEPTH            = deq_pkg::DEPTH_DEFAULT;
   localparam int STALL_LIMIT      = 20000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int END_DRAIN_CYCLES = 64;
   localparam int MAX_REPORTS      = 10;

   // func codes the block treats as no operation
   localparam logic [deq_pkg::FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [deq_pkg::FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [deq_pkg::FUNC_W-1:0]         func;
      logic signed [deq_pkg::VALUE_W-1:0] value;
      logic [deq_pkg::POS_W-1:0]          position;
   } deq_op_type;

   typedef struct packed {
      logic signed [deq_pkg::VALUE_W-1:0] read_data;
      logic [deq_pkg::OCC_W-1:0]          occupancy;
      logic [deq_pkg::STATUS_W-1:0]       status;
   } deq_outcome_type;

   logic clock;
   logic reset;

   deq_req_if req_if ();
   deq_rsp_if rsp_if ();

   double_ended_queue_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   // mirror of the deque contents
   logic signed [deq_pkg::VALUE_W-1:0] ring_word [DEPTH];
   logic [deq_pkg::POS_W-1:0]          ring_front;
   logic [deq_pkg::POS_W-1:0]          ring_back;
   logic [deq_pkg::OCC_W-1:0]          ring_count;

   deq_op_type      op_backlog [$];
   deq_outcome_type deque_outcomes [$];
   deq_op_type      live_op;
   deq_outcome_type want;
   logic            req_fire;

   int fail_count = 0;
   int quiet_cycles = 0;
   int gen_count;
   int send_idle_pct;
   int rcv_stall_pct;
   int hold_left;
   logic long_hold_arm;
   logic long_hold_done;

   always #10 clock = ~clock;

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("mismatch: %s", msg);
   endfunction

   // apply one operation to the mirror and return what the block must answer
   function automatic deq_outcome_type deque_apply(input deq_op_type op);
      deq_outcome_type r;
      logic [deq_pkg::POS_W-1:0] slot;
      r.read_data = '0;
      r.status = deq_pkg::ST_OK;
      slot = ring_front + op.position;
      case (op.func) inside
         deq_pkg::FUNC_PUSH_BACK, deq_pkg::FUNC_PUSH_FRONT: begin
            if (ring_count >= DEPTH) begin
               r.status = deq_pkg::ST_FULL;
            end else if (op.func == deq_pkg::FUNC_PUSH_BACK) begin
               ring_word[ring_back] = op.value;
               ring_back = ring_back + 1'b1;
               ring_count = ring_count + 1'b1;
            end else begin
               ring_front = ring_front - 1'b1;
               ring_word[ring_front] = op.value;
               ring_count = ring_count + 1'b1;
            end
         end
         deq_pkg::FUNC_POP_BACK, deq_pkg::FUNC_POP_FRONT: begin
            if (ring_count == 0) begin
               r.status = deq_pkg::ST_EMPTY;
            end else if (op.func == deq_pkg::FUNC_POP_BACK) begin
               ring_back = ring_back - 1'b1;
               ring_count = ring_count - 1'b1;
            end else begin
               ring_front = ring_front + 1'b1;
               ring_count = ring_count - 1'b1;
            end
         end
         deq_pkg::FUNC_READ, deq_pkg::FUNC_WRITE: begin
            if ({1'b0, op.position} >= ring_count) begin
               r.status = deq_pkg::ST_RANGE;
            end else if (op.func == deq_pkg::FUNC_READ) begin
               r.read_data = ring_word[slot];
            end else begin
               ring_word[slot] = op.value;
            end
         end
         default: ;
      endcase
      r.occupancy = ring_count;
      return r;
   endfunction

   // queue an operation and track the occupancy it leads to
   function automatic void add_op(input logic [deq_pkg::FUNC_W-1:0] f,
                                  input logic [deq_pkg::VALUE_W-1:0] v,
                                  input logic [deq_pkg::POS_W-1:0] p);
      deq_op_type op;
      op.func = f;
      op.value = v;
      op.position = p;
      op_backlog = {op_backlog, op};
      if ((f == deq_pkg::FUNC_PUSH_BACK || f == deq_pkg::FUNC_PUSH_FRONT) && gen_count < DEPTH)
         gen_count++;
      else if ((f == deq_pkg::FUNC_POP_BACK || f == deq_pkg::FUNC_POP_FRONT) && gen_count > 0)
         gen_count--;
   endfunction

   function automatic logic [deq_pkg::VALUE_W-1:0] rand_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 32'h7FFF_FFFF;
      if (r < 16) return 32'h8000_0000;
      if (r < 20) return '0;
      if (r < 24) return '1;
      return $urandom;
   endfunction

   function automatic logic [deq_pkg::POS_W-1:0] any_position();
      return deq_pkg::POS_W'($urandom_range(0, DEPTH - 1));
   endfunction

   // mostly small in-range positions, some at the boundary, some anywhere
   function automatic logic [deq_pkg::POS_W-1:0] pick_position();
      int r;
      int hi;
      r = $urandom_range(0, 99);
      if (gen_count == 0 || r < 8) return any_position();
      if (r < 16) return deq_pkg::POS_W'(gen_count);
      if (r < 24) return deq_pkg::POS_W'(gen_count - 1);
      hi = (gen_count - 1 < 47) ? gen_count - 1 : 47;
      return deq_pkg::POS_W'($urandom_range(0, hi));
   endfunction

   function automatic void gen_random(input int n, input int push_w, input int pop_w);
      int k;
      int sel;
      logic [deq_pkg::FUNC_W-1:0] f;
      logic [deq_pkg::POS_W-1:0] p;
      for (k = 0; k < n; k++) begin
         sel = $urandom_range(0, 99);
         p = any_position();
         if (sel < push_w)
            f = $urandom_range(0, 1) ? deq_pkg::FUNC_PUSH_BACK : deq_pkg::FUNC_PUSH_FRONT;
         else if (sel < push_w + pop_w)
            f = $urandom_range(0, 1) ? deq_pkg::FUNC_POP_BACK : deq_pkg::FUNC_POP_FRONT;
         else if (sel < 97)
            f = $urandom_range(0, 1) ? deq_pkg::FUNC_READ : deq_pkg::FUNC_WRITE;
         else
            f = $urandom_range(0, 1) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
         if (f == deq_pkg::FUNC_READ || f == deq_pkg::FUNC_WRITE)
            p = pick_position();
         add_op(f, rand_word(), p);
      end
   endfunction

   // sampled off the active edge, so the driver's updates are settled
   task automatic wait_drained();
      @(negedge clock);
      while (op_backlog.size() != 0 || req_if.valid || deque_outcomes.size() != 0)
         @(negedge clock);
   endtask

   // request driver: hold an item until its transfer, then maybe offer the next
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid    <= 1'b0;
         req_if.func     <= '0;
         req_if.value    <= '0;
         req_if.position <= '0;
         ring_front = '0;
         ring_back  = '0;
         ring_count = '0;
      end else begin
         req_fire = req_if.valid && req_if.ready;
         if (req_fire)
            deque_outcomes = {deque_outcomes, deque_apply(live_op)};
         if (!req_if.valid || req_fire) begin
            if (op_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               live_op = op_backlog[0];
               op_backlog.delete(0);
               req_if.func <= live_op.func;
               req_if.value <= live_op.value;
               req_if.position <= live_op.position;
               req_if.valid <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left = 0;
         long_hold_done = 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (deque_outcomes.size() == 0) begin
               note_failure($sformatf("result with nothing due: data %h occ %0d status %0d",
                                      rsp_if.read_data, rsp_if.occupancy, rsp_if.status));
            end else begin
               want = deque_outcomes[0];
               deque_outcomes.delete(0);
               if (rsp_if.read_data !== want.read_data || rsp_if.occupancy !== want.occupancy
                   || rsp_if.status !== want.status)
                  note_failure($sformatf(
                     "expected data %h occ %0d status %0d, got data %h occ %0d status %0d",
                     want.read_data, want.occupancy, want.status,
                     rsp_if.read_data, rsp_if.occupancy, rsp_if.status));
            end
         end
         // one long hold-off so the block backs up into the request side
         if (long_hold_arm && !long_hold_done) begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      gen_count = 0;
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      long_hold_arm = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pops, out of range, spare codes, extremes, ring wrap
      add_op(deq_pkg::FUNC_POP_BACK, '0, '0);
      add_op(deq_pkg::FUNC_POP_FRONT, '0, '0);
      add_op(deq_pkg::FUNC_READ, '0, '0);
      add_op(deq_pkg::FUNC_WRITE, 32'h1234_5678, '0);
      add_op(FUNC_SPARE_LO, '1, '1);
      add_op(FUNC_SPARE_HI, '1, '1);
      add_op(deq_pkg::FUNC_PUSH_BACK, 32'h7FFF_FFFF, '0);
      add_op(deq_pkg::FUNC_PUSH_FRONT, 32'h8000_0000, '1);
      add_op(deq_pkg::FUNC_PUSH_BACK, '0, '0);
      add_op(deq_pkg::FUNC_PUSH_FRONT, '1, '0);
      add_op(deq_pkg::FUNC_READ, '0, 10'd0);
      add_op(deq_pkg::FUNC_READ, '0, 10'd3);
      add_op(deq_pkg::FUNC_READ, '0, 10'd4);
      add_op(deq_pkg::FUNC_READ, '0, 10'd1023);
      add_op(deq_pkg::FUNC_WRITE, 32'h5A5A_5A5A, 10'd2);
      add_op(deq_pkg::FUNC_READ, '0, 10'd2);
      add_op(deq_pkg::FUNC_WRITE, 32'hA5A5_A5A5, 10'd4);
      add_op(deq_pkg::FUNC_POP_BACK, '0, '0);
      add_op(deq_pkg::FUNC_POP_FRONT, '0, '0);
      add_op(deq_pkg::FUNC_READ, '0, 10'd0);
      add_op(deq_pkg::FUNC_READ, '0, 10'd1);
      add_op(deq_pkg::FUNC_POP_FRONT, '0, '0);
      add_op(deq_pkg::FUNC_POP_BACK, '0, '0);
      add_op(deq_pkg::FUNC_POP_BACK, '0, '0);
      wait_drained();

      // random phases, each ending with a full drain of results
      send_idle_pct <= 0;
      rcv_stall_pct <= 0;
      gen_random(150, 30, 28);
      wait_drained();
      send_idle_pct <= 53;
      rcv_stall_pct <= 0;
      gen_random(150, 30, 28);
      wait_drained();
      send_idle_pct <= 0;
      rcv_stall_pct <= 53;
      gen_random(150, 30, 28);
      wait_drained();
      send_idle_pct <= 32;
      rcv_stall_pct <= 32;
      gen_random(150, 30, 28);
      wait_drained();

      // fill to capacity behind a long receiver hold-off, then probe deep
      send_idle_pct <= 0;
      rcv_stall_pct <= 0;
      long_hold_arm <= 1'b1;
      while (gen_count < DEPTH)
         add_op($urandom_range(0, 1) ? deq_pkg::FUNC_PUSH_BACK : deq_pkg::FUNC_PUSH_FRONT,
                rand_word(), any_position());
      add_op(deq_pkg::FUNC_PUSH_BACK, rand_word(), '0);
      add_op(deq_pkg::FUNC_PUSH_FRONT, rand_word(), '0);
      add_op(deq_pkg::FUNC_READ, '0, 10'd1023);
      add_op(deq_pkg::FUNC_WRITE, 32'hC3C3_3C3C, 10'd1023);
      add_op(deq_pkg::FUNC_READ, '0, 10'd1023);
      add_op(deq_pkg::FUNC_READ, '0, 10'd511);
      wait_drained();

      // drain-heavy mix with both sides idling
      send_idle_pct <= 32;
      rcv_stall_pct <= 32;
      gen_random(220, 15, 45);
      wait_drained();

      repeat (END_DRAIN_CYCLES) @(posedge clock);
      if (deque_outcomes.size() != 0)
         note_failure($sformatf("%0d results never arrived", deque_outcomes.size()));
      if (fail_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

// File: files.f
design/deq_pkg.sv
design/deq_req_if.sv
design/deq_rsp_if.sv
design/deq_cell.sv
design/double_ended_queue_unit.sv
tb/sv/tb.sv
